@@ rtl/olfs_pkg.sv @@
// Shared types and constants for the oxygen level filter and scaler.
// Transaction payloads, register indexes, status codes and fixed widths.
// No dependencies.
`default_nettype none

package olfs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OXY_W      = 12;
    localparam int STATUS_W   = 2;
    localparam int WIN_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = SAMPLE_W + WIN_W;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int NUM_W      = 28;
    localparam int K_W        = 12;
    localparam int PROD_W     = DIFF_W + K_W;
    localparam int SCALE_K    = 2090;
    localparam int OXY_MAX    = 3000;
    localparam int WIN_RESET  = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_CAL_ZERO   = 3'd0;
    localparam t_cfg_idx REG_CAL_AIR    = 3'd1;
    localparam t_cfg_idx REG_CAL_VALID  = 3'd2;
    localparam t_cfg_idx REG_FILTER_ON  = 3'd3;
    localparam t_cfg_idx REG_WINDOW_LEN = 3'd4;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_NOCAL  = 2'd1;
    localparam t_status ST_BADCAL = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [OXY_W-1:0]           oxygen_hundredths;
        t_status                    status;
        logic signed [SAMPLE_W-1:0] filtered_sample;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/olfs_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is set at instantiation; no other dependencies.
`default_nettype none

interface olfs_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/olfs_ring.sv @@
// Sample ring memory: one write and one registered read port per cycle.
// Per-entry valid bits make never-written entries read as zero. Uses olfs_pkg.
`default_nettype none

module olfs_ring #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [IDX_W-1:0]                    i_wr_addr,
    input  wire logic signed [olfs_pkg::SAMPLE_W-1:0] i_wr_data,
    input  wire logic                                i_rd_en,
    input  wire logic [IDX_W-1:0]                    i_rd_addr,
    output logic signed [olfs_pkg::SAMPLE_W-1:0]     o_rd_data
);

    logic signed [olfs_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [olfs_pkg::SAMPLE_W-1:0] r_rd_raw;
    logic [DEPTH-1:0]                     r_vld;
    logic                                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

`default_nettype wire

@@ rtl/olfs_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Start pulse loads operands; done pulses when the quotient is ready. No deps.
`default_nettype none

module olfs_div #(
    parameter int N_W = 28,
    parameter int D_W = 17
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_done,
    output logic [N_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [D_W:0]     w_shift;
    logic [D_W:0]     w_trial;
    logic             w_fit;

    assign w_shift = {r_rem, r_quo[N_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_fit   = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], w_fit};
            r_rem <= w_fit ? w_trial[D_W-1:0] : w_shift[D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ rtl/oxygen_level_filter_and_scale.sv @@
// Channel   Dir  Payload                                          Handshake
// i_in      in   sample (s16)                                     valid/ready
// o_out     out  oxygen_hundredths (u12), status (u2),            valid/ready
//                filtered_sample (s16)
// i_cfg     in   i_cfg_idx, i_cfg_data                            i_cfg_we
// One transaction in flight. Filter on: a window read walk through the ring port, then
// an averaging divider run and a scaling divider run (skipped on equal cal points or a negative ratio).
// Filter off: only the scaling divider run. Not calibrated: a NOCAL result, no arithmetic.
// A finished result waits until the output register is free; the next input is taken once it has moved there.
// Synchronous active-low reset; ring entries read as zero until written.
`default_nettype none

module oxygen_level_filter_and_scale #(
    parameter int WINDOW_MAX = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    olfs_stream_if.sink                            i_in,
    olfs_stream_if.source                          o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [olfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [olfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = (IDX_W + 1 > olfs_pkg::WIN_W) ? IDX_W + 1 : olfs_pkg::WIN_W;
    localparam int WIN_RST = (olfs_pkg::WIN_RESET <= WINDOW_MAX) ?
                             olfs_pkg::WIN_RESET : WINDOW_MAX;
    localparam int SW = olfs_pkg::SAMPLE_W;
    localparam int DW = olfs_pkg::DIFF_W;
    localparam int NW = olfs_pkg::NUM_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SUM    = 7'b0000010,
        S_AVG    = 7'b0000100,
        S_DIFF   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_QSTART = 7'b0100000,
        S_QUO    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic signed [SW-1:0]          r_cal_zero;
    logic signed [SW-1:0]          r_cal_air;
    logic                          r_cal_valid;
    logic                          r_filter_on;
    logic [olfs_pkg::WIN_W-1:0]    r_win;

    logic [IDX_W-1:0]              r_pos;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              r_mod;
    logic                          r_rd_pend;
    logic signed [olfs_pkg::SUM_W-1:0] r_acc;
    logic                          r_sum_neg;
    logic signed [SW-1:0]          r_x;
    logic signed [DW-1:0]          r_diff;
    logic signed [DW-1:0]          r_den;
    logic [DW-1:0]                 r_den_mag;
    logic [NW-1:0]                 r_num_mag;
    logic                          r_neg;
    logic                          r_res_vld;
    olfs_pkg::t_out_item           r_res;
    logic                          r_out_vld;
    olfs_pkg::t_out_item           r_out;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic [CNT_W-1:0]              w_win_ext;
    logic                          w_rd_en;
    logic                          w_sum_done;
    logic                          w_ring_we;
    logic signed [SW-1:0]          w_rd_data;
    logic [olfs_pkg::SUM_W-1:0]    w_acc_mag;
    logic                          w_div_start;
    logic [NW-1:0]                 w_div_num;
    logic [DW-1:0]                 w_div_den;
    logic                          w_div_done;
    logic [NW-1:0]                 w_div_quo;
    logic [DW-1:0]                 w_avg_mag;
    logic [DW-1:0]                 w_avg;
    logic [DW-1:0]                 w_diff_mag;
    logic [DW-1:0]                 w_den_mag;
    logic [olfs_pkg::PROD_W-1:0]   w_prod;
    logic [olfs_pkg::WIN_W-1:0]    w_cfg_win;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_res_vld;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_win_ext  = CNT_W'(r_win);
    assign w_ring_we  = w_in_acc && r_cal_valid && r_filter_on;
    assign w_rd_en    = (r_state == S_SUM) && (r_cnt < w_win_ext);
    assign w_sum_done = (r_state == S_SUM) && !w_rd_en && !r_rd_pend && (r_mod < w_win_ext);
    assign w_acc_mag  = r_acc[olfs_pkg::SUM_W-1] ? (-r_acc) : r_acc;

    assign w_div_start = w_sum_done || ((r_state == S_QSTART) && !r_neg);
    assign w_div_num   = (r_state == S_SUM) ? NW'(w_acc_mag) : r_num_mag;
    assign w_div_den   = (r_state == S_SUM) ? DW'(r_win) : r_den_mag;

    assign w_avg_mag  = w_div_quo[DW-1:0];
    assign w_avg      = r_sum_neg ? (-w_avg_mag) : w_avg_mag;
    assign w_diff_mag = r_diff[DW-1] ? (-r_diff) : r_diff;
    assign w_den_mag  = r_den[DW-1] ? (-r_den) : r_den;
    assign w_prod     = olfs_pkg::PROD_W'(w_diff_mag) * olfs_pkg::PROD_W'(olfs_pkg::SCALE_K);
    assign w_cfg_win  = i_cfg_data[olfs_pkg::WIN_W-1:0];

    olfs_ring #(
        .DEPTH (WINDOW_MAX),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_ring_we),
        .i_wr_addr (r_pos),
        .i_wr_data (i_in.payload.sample),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_cnt[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    olfs_div #(
        .N_W (NW),
        .D_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_zero  <= '0;
            r_cal_air   <= '0;
            r_cal_valid <= 1'b0;
            r_filter_on <= 1'b1;
            r_win       <= olfs_pkg::WIN_W'(WIN_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                olfs_pkg::REG_CAL_ZERO:   r_cal_zero  <= i_cfg_data;
                olfs_pkg::REG_CAL_AIR:    r_cal_air   <= i_cfg_data;
                olfs_pkg::REG_CAL_VALID:  r_cal_valid <= i_cfg_data[0];
                olfs_pkg::REG_FILTER_ON:  r_filter_on <= i_cfg_data[0];
                olfs_pkg::REG_WINDOW_LEN: begin
                    if (w_cfg_win != '0 && int'(w_cfg_win) <= WINDOW_MAX) begin
                        r_win <= w_cfg_win;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && r_cal_valid) begin
                    n_state = r_filter_on ? S_SUM : S_DIFF;
                end
            end
            S_SUM:    if (w_sum_done) n_state = S_AVG;
            S_AVG:    if (w_div_done) n_state = S_DIFF;
            S_DIFF:   n_state = (r_cal_air == r_cal_zero) ? S_IDLE : S_MUL;
            S_MUL:    n_state = S_QSTART;
            S_QSTART: n_state = r_neg ? S_IDLE : S_QUO;
            S_QUO:    if (w_div_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_rd_pend <= 1'b0;
            r_res_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_rd_en;
            if (w_sum_done) begin
                r_pos <= r_mod[IDX_W-1:0];
            end
            if (r_res_vld && w_out_free) begin
                r_res_vld <= 1'b0;
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if ((w_in_acc && !r_cal_valid) ||
                ((r_state == S_DIFF) && (r_cal_air == r_cal_zero)) ||
                ((r_state == S_QSTART) && r_neg) ||
                ((r_state == S_QUO) && w_div_done)) begin
                r_res_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res_vld && w_out_free) begin
            r_out <= r_res;
        end
        case (r_state)
            S_IDLE: begin
                r_x   <= i_in.payload.sample;
                r_cnt <= '0;
                r_acc <= '0;
                r_mod <= CNT_W'(r_pos) + CNT_W'(1);
                if (!r_cal_valid) begin
                    r_res.oxygen_hundredths <= '0;
                    r_res.status            <= olfs_pkg::ST_NOCAL;
                    r_res.filtered_sample   <= '0;
                end
            end
            S_SUM: begin
                if (w_rd_en) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (r_rd_pend) begin
                    r_acc <= r_acc + olfs_pkg::SUM_W'(w_rd_data);
                end
                if (r_mod >= w_win_ext) begin
                    r_mod <= r_mod - w_win_ext;
                end
                r_sum_neg <= r_acc[olfs_pkg::SUM_W-1];
            end
            S_AVG: begin
                if (w_div_done) begin
                    r_x <= w_avg[SW-1:0];
                end
            end
            S_DIFF: begin
                r_diff <= {r_x[SW-1], r_x} - {r_cal_zero[SW-1], r_cal_zero};
                r_den  <= {r_cal_air[SW-1], r_cal_air} - {r_cal_zero[SW-1], r_cal_zero};
                r_res.oxygen_hundredths <= '0;
                r_res.status            <= olfs_pkg::ST_BADCAL;
                r_res.filtered_sample   <= r_x;
            end
            S_MUL: begin
                r_num_mag <= w_prod[NW-1:0];
                r_den_mag <= w_den_mag;
                r_neg     <= r_diff[DW-1] ^ r_den[DW-1];
            end
            S_QSTART: begin
                r_res.oxygen_hundredths <= '0;
                r_res.status            <= olfs_pkg::ST_OK;
            end
            S_QUO: begin
                if (w_div_quo > NW'(olfs_pkg::OXY_MAX)) begin
                    r_res.oxygen_hundredths <= olfs_pkg::OXY_W'(olfs_pkg::OXY_MAX);
                end else begin
                    r_res.oxygen_hundredths <= w_div_quo[olfs_pkg::OXY_W-1:0];
                end
                r_res.status <= olfs_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

@@ rtl/olfs_chk.sv @@
// Port-level checker for oxygen_level_filter_and_scale, bound to the top level.
// Uses olfs_pkg for payload type and status codes.
`default_nettype none

module olfs_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire olfs_pkg::t_out_item out_payload
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("output transaction changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_payload.oxygen_hundredths <= 12'(olfs_pkg::OXY_MAX)) &&
                      (out_payload.status == olfs_pkg::ST_OK ||
                       out_payload.status == olfs_pkg::ST_NOCAL ||
                       out_payload.status == olfs_pkg::ST_BADCAL))
        else $error("oxygen or status out of range");

    a_nocal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_payload.status != olfs_pkg::ST_OK |->
            out_payload.oxygen_hundredths == '0 &&
            (out_payload.status != olfs_pkg::ST_NOCAL || out_payload.filtered_sample == '0))
        else $error("error status with nonzero result fields");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid right after reset");

endmodule

bind oxygen_level_filter_and_scale olfs_chk u_olfs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in.valid),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .out_payload (o_out.payload)
);

`default_nettype wire
